@@ rtl/wss_pkg.sv @@
// shared constants and request types for the word similarity scorer
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wss_pkg;

  localparam int DEF_MAX_LEN = 32;
  localparam int CH_W        = 16;
  localparam int CMD_W       = 2;
  localparam int SIM_W       = 17;
  localparam int MATCH_W     = 6;
  localparam int DIV_STEPS   = 17;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CMD_W-1:0] CMD_FIRST    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SECOND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;
  // unused code, ignored by the block
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  typedef struct packed {
    logic first_we;
    logic second_we;
  } word_we_t;

  typedef struct packed {
    logic kept_we;
    logic chain_we;
  } scratch_we_t;

endpackage

`default_nettype wire

@@ rtl/wss_word_store.sv @@
// character storage for the two words, one synchronous memory each
// depends on wss_pkg
`timescale 1ns / 1ps
`default_nettype none

module wss_word_store #(
  parameter int MAX_LEN = wss_pkg::DEF_MAX_LEN,
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  wire logic                    clk,
  input  wire wss_pkg::word_we_t       we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [wss_pkg::CH_W-1:0] wdata,
  input  wire logic [AW-1:0]           first_raddr,
  input  wire logic [AW-1:0]           second_raddr,
  output logic      [wss_pkg::CH_W-1:0] first_rdata,
  output logic      [wss_pkg::CH_W-1:0] second_rdata
);

  logic [wss_pkg::CH_W-1:0] first_mem  [MAX_LEN];
  logic [wss_pkg::CH_W-1:0] second_mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (we.first_we) begin
      first_mem[waddr] <= wdata;
    end
    first_rdata <= first_mem[first_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.second_we) begin
      second_mem[waddr] <= wdata;
    end
    second_rdata <= second_mem[second_raddr];
  end

endmodule

`default_nettype wire

@@ rtl/wss_scratch.sv @@
// scratch memories for the compute pass: kept positions and chain tail/length
// depends on wss_pkg; read data is forwarded when read and write hit one entry
`timescale 1ns / 1ps
`default_nettype none

module wss_scratch #(
  parameter int MAX_LEN = wss_pkg::DEF_MAX_LEN,
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  wire logic                  clk,
  input  wire wss_pkg::scratch_we_t  we,
  input  wire logic [AW-1:0]         kept_waddr,
  input  wire logic [AW-1:0]         kept_wdata,
  input  wire logic [AW-1:0]         kept_raddr,
  output logic      [AW-1:0]         kept_rdata,
  input  wire logic [AW-1:0]         chain_waddr,
  input  wire logic [AW-1:0]         chain_wtail,
  input  wire logic [LW-1:0]         chain_wlen,
  input  wire logic [AW-1:0]         chain_raddr,
  output logic      [AW-1:0]         chain_rtail,
  output logic      [LW-1:0]         chain_rlen
);

  logic [AW-1:0] kept_mem [MAX_LEN];
  logic [AW+LW-1:0] chain_mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (we.kept_we) begin
      kept_mem[kept_waddr] <= kept_wdata;
    end
    if (we.kept_we && (kept_waddr == kept_raddr)) begin
      kept_rdata <= kept_wdata;
    end else begin
      kept_rdata <= kept_mem[kept_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we.chain_we) begin
      chain_mem[chain_waddr] <= {chain_wtail, chain_wlen};
    end
    if (we.chain_we && (chain_waddr == chain_raddr)) begin
      {chain_rtail, chain_rlen} <= {chain_wtail, chain_wlen};
    end else begin
      {chain_rtail, chain_rlen} <= chain_mem[chain_raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/word_similarity_score.sv @@
// top level of the word similarity scorer: command decode, compute sequencer, divider
// depends on wss_pkg, wss_word_store, wss_scratch
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_stall    cmd, ch
// out      source     out_valid / out_stall  similarity, match_len, overflow
//
// a load request stores one character; a compute request runs a scan that
// probes the first word for each char of word two, then the chain pass
// over the kept positions, then the restoring divider
// chain pass and divider are skipped when no position is kept
// one memory read per cycle on each store paces the scan and the chain pass
// in_stall is high from a compute request until its result enters the output register
// rst is synchronous; lengths, overflow flag and output valid clear, memories do not
`timescale 1ns / 1ps
`default_nettype none

module word_similarity_score #(
  parameter int MAX_LEN = wss_pkg::DEF_MAX_LEN
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [wss_pkg::CMD_W-1:0]     cmd,
  input  wire logic [wss_pkg::CH_W-1:0]      ch,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [wss_pkg::SIM_W-1:0]     similarity,
  output logic      [wss_pkg::MATCH_W-1:0]   match_len,
  output logic                               overflow
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int TW = LW + 1;
  localparam int RW = LW + 2;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_CHAIN = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state, state_next;
  logic [LW-1:0] flen, flen_next, slen, slen_next;
  logic ovf, ovf_next;
  logic [LW-1:0] j, j_next, p, p_next, kept_cnt, kept_cnt_next;
  logic [LW-1:0] k, k_next, n, n_next, best, best_next;
  logic [TW-1:0] total, total_next;
  logic [RW-1:0] rem, rem_next;
  logic [wss_pkg::SIM_W-1:0] quo, quo_next;
  logic [wss_pkg::DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic out_load;

  wss_pkg::word_we_t    word_we;
  wss_pkg::scratch_we_t scr_we;
  logic [AW-1:0] word_waddr;
  logic [wss_pkg::CH_W-1:0] f_rd, s_rd;
  logic [AW-1:0] kept_waddr, kept_wdata, kept_rd;
  logic [AW-1:0] chain_waddr, chain_wtail, chain_rtail;
  logic [LW-1:0] chain_wlen, chain_rlen;

  wss_word_store #(.MAX_LEN(MAX_LEN)) u_words (
    .clk          (clk),
    .we           (word_we),
    .waddr        (word_waddr),
    .wdata        (ch),
    .first_raddr  (p_next[AW-1:0]),
    .second_raddr (j_next[AW-1:0]),
    .first_rdata  (f_rd),
    .second_rdata (s_rd)
  );

  wss_scratch #(.MAX_LEN(MAX_LEN)) u_scratch (
    .clk         (clk),
    .we          (scr_we),
    .kept_waddr  (kept_waddr),
    .kept_wdata  (kept_wdata),
    .kept_raddr  (k_next[AW-1:0]),
    .kept_rdata  (kept_rd),
    .chain_waddr (chain_waddr),
    .chain_wtail (chain_wtail),
    .chain_wlen  (chain_wlen),
    .chain_raddr (n_next[AW-1:0]),
    .chain_rtail (chain_rtail),
    .chain_rlen  (chain_rlen)
  );

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    logic hit, keep;
    logic [LW:0] p1, j1, k1;
    logic [LW-1:0] len1;
    logic ge;
    logic [RW-1:0] sub;
    state_next    = state;
    flen_next     = flen;
    slen_next     = slen;
    ovf_next      = ovf;
    j_next        = j;
    p_next        = p;
    kept_cnt_next = kept_cnt;
    k_next        = k;
    n_next        = n;
    best_next     = best;
    total_next    = total;
    rem_next      = rem;
    quo_next      = quo;
    div_cnt_next  = div_cnt;
    out_load      = 1'b0;
    word_we       = '0;
    scr_we        = '0;
    word_waddr    = '0;
    kept_waddr    = kept_cnt[AW-1:0];
    kept_wdata    = p[AW-1:0];
    chain_waddr   = n[AW-1:0];
    chain_wtail   = kept_rd;
    chain_wlen    = '0;
    hit  = (f_rd == s_rd);
    keep = (({1'b0, p} + {1'b0, slen}) <= ({1'b0, j} + {1'b0, flen}));
    p1   = {1'b0, p} + 1'b1;
    j1   = {1'b0, j} + 1'b1;
    k1   = {1'b0, k} + 1'b1;
    len1 = chain_rlen + 1'b1;
    ge   = (rem >= {1'b0, total});
    sub  = ge ? (rem - {1'b0, total}) : rem;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            wss_pkg::CMD_FIRST: begin
              if (flen != LEN_MAX) begin
                word_we.first_we = 1'b1;
                word_waddr       = flen[AW-1:0];
                flen_next        = flen + 1'b1;
              end else begin
                ovf_next = 1'b1;
              end
            end
            wss_pkg::CMD_SECOND: begin
              if (slen != LEN_MAX) begin
                word_we.second_we = 1'b1;
                word_waddr        = slen[AW-1:0];
                slen_next         = slen + 1'b1;
              end else begin
                ovf_next = 1'b1;
              end
            end
            wss_pkg::CMD_COMPUTE: begin
              total_next    = {1'b0, flen} + {1'b0, slen};
              best_next     = '0;
              quo_next      = '0;
              j_next        = '0;
              p_next        = '0;
              kept_cnt_next = '0;
              if ((flen == '0) || (slen == '0)) begin
                state_next = ST_DONE;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit || (p1 >= {1'b0, flen})) begin
          if (hit && keep) begin
            scr_we.kept_we = 1'b1;
            kept_cnt_next  = kept_cnt + 1'b1;
          end
          if ((j1 >= {1'b0, slen}) || (j1 >= {1'b0, flen})) begin
            k_next = '0;
            n_next = '0;
            state_next = (kept_cnt_next == '0) ? ST_DONE : ST_CHAIN;
          end else begin
            j_next = j1[LW-1:0];
            p_next = j1[LW-1:0];
          end
        end else begin
          p_next = p1[LW-1:0];
        end
      end
      ST_CHAIN: begin
        if (n == k) begin
          // open a new chain holding only this position
          scr_we.chain_we = 1'b1;
          chain_waddr     = k[AW-1:0];
          chain_wlen      = LW'(1);
          if (best == '0) begin
            best_next = LW'(1);
          end
          n_next = '0;
          if (k1 == {1'b0, kept_cnt}) begin
            rem_next     = {1'b0, best_next, 1'b0};
            div_cnt_next = '0;
            state_next   = ST_DIV;
          end else begin
            k_next = k1[LW-1:0];
          end
        end else begin
          if (chain_rtail < kept_rd) begin
            scr_we.chain_we = 1'b1;
            chain_wlen      = len1;
            if (len1 > best) begin
              best_next = len1;
            end
          end
          n_next = n + 1'b1;
        end
      end
      ST_DIV: begin
        // restoring division of 2*best by total, one quotient bit a cycle
        quo_next = {quo[wss_pkg::SIM_W-2:0], ge};
        if (div_cnt == wss_pkg::DIV_CNT_W'(wss_pkg::DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end else begin
          rem_next     = {sub[RW-2:0], 1'b0};
          div_cnt_next = div_cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          flen_next  = '0;
          slen_next  = '0;
          ovf_next   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      flen      <= '0;
      slen      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      flen  <= flen_next;
      slen  <= slen_next;
      ovf   <= ovf_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    j        <= j_next;
    p        <= p_next;
    kept_cnt <= kept_cnt_next;
    k        <= k_next;
    n        <= n_next;
    best     <= best_next;
    total    <= total_next;
    rem      <= rem_next;
    quo      <= quo_next;
    div_cnt  <= div_cnt_next;
    if (out_load) begin
      similarity <= quo;
      match_len  <= wss_pkg::MATCH_W'(best);
      overflow   <= ovf;
    end
  end

  a_chain_has_kept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHAIN) |-> ((kept_cnt != '0) && (k < kept_cnt)))
    else $error("chain pass without kept positions");

  a_chain_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHAIN) |-> (n <= k))
    else $error("chain index past the current kept position");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < ({1'b0, total} << 1)))
    else $error("divider remainder out of range");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && (!out_valid || !out_stall))
      |=> (out_valid && (flen == '0) && (slen == '0) && !ovf))
    else $error("result issued without clearing the words");

endmodule

`default_nettype wire
